// ===== rtl/tld_pkg.sv =====
// tld_pkg: shared constants and controller/datapath interface types
// for the lzw strip decoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tld_pkg;

  localparam int unsigned MaxCodeBits = 12;
  localparam int unsigned CodeW       = MaxCodeBits;
  localparam int unsigned TableSize   = 1 << MaxCodeBits;
  localparam int unsigned StackDepth  = 4096;
  localparam int unsigned StackAw     = $clog2(StackDepth);

  localparam logic [12:0] CODE_CLEAR = 13'd256;
  localparam logic [12:0] END_CODE   = 13'd257;
  localparam logic [12:0] FIRST_FREE = 13'd258;
  localparam logic [12:0] TABLE_LIM  = 13'(TableSize);
  localparam logic [12:0] STACK_LIM  = 13'(StackDepth);
  localparam logic [3:0]  MIN_WIDTH  = 4'd9;
  localparam logic [3:0]  MAX_WIDTH  = 4'(MaxCodeBits);
  localparam logic [4:0]  PUSH_ROOM  = 5'd16;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  typedef struct packed {
    logic latch_item;
    logic do_push;
    logic do_decode;
    logic unwind_step;
    logic do_pop;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic item_is_pull;
    logic can_decode;
    logic start_unwind;
    logic unwind_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/tld_ctrl.sv =====
// tld_ctrl: sequencing state machine for the lzw decoder
// depends on tld_pkg; drives tld_datapath through ctl_t
`timescale 1ns / 1ps
`default_nettype none
module tld_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire tld_pkg::sts_t  sts,
  output tld_pkg::ctl_t       ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_UNWIND = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch_item = 1'b1;
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.item_is_pull) begin
          ctl.do_push = 1'b1;
          state_nxt   = S_RESP;
        end else if (sts.can_decode) begin
          ctl.do_decode = 1'b1;
          state_nxt     = sts.start_unwind ? S_UNWIND : S_POP;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_UNWIND: begin
        ctl.unwind_step = 1'b1;
        if (sts.unwind_done) state_nxt = S_POP;
      end
      S_POP: begin
        ctl.do_pop = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/tld_datapath.sv =====
// tld_datapath: bit buffer, string table, string stack and result register
// depends on tld_pkg; commanded by tld_ctrl
`timescale 1ns / 1ps
`default_nettype none
module tld_datapath (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_cmd,
  input  wire logic [7:0]     in_byte,
  input  wire logic           out_stall,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                out_byte_valid,
  output logic                out_last_of_string,
  output logic                out_push_accepted,
  output logic                out_need_input,
  output logic                out_end_of_data,
  input  wire tld_pkg::ctl_t  ctl,
  output tld_pkg::sts_t       sts
);

  localparam int unsigned CW = tld_pkg::CodeW;
  localparam int unsigned SA = tld_pkg::StackAw;

  // item
  logic       item_cmd_r;
  logic [7:0] item_byte_r;

  // decoder state
  logic [23:0]   buf_r, buf_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [3:0]    width_r, width_nxt;
  logic [12:0]   nfc_r, nfc_nxt;
  logic [CW-1:0] prev_r, prev_nxt;
  logic [7:0]    prev_first_r, prev_first_nxt;
  logic          fac_r, fac_nxt;
  logic          fin_r, fin_nxt;
  logic [12:0]   level_r, level_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] code_r, code_nxt;
  logic          kwk_r, kwk_nxt;

  // memories
  logic [CW+7:0] entry_mem [tld_pkg::TableSize];
  logic [CW+7:0] entry_q;
  logic [CW-1:0] entry_raddr;
  logic          entry_we;
  logic [CW+7:0] entry_wdata;
  logic [7:0]    stack_mem [tld_pkg::StackDepth];
  logic [7:0]    stack_q;
  logic [SA-1:0] stack_raddr_r, stack_raddr_nxt;
  logic          stack_we;
  logic [7:0]    stack_wdata;

  // pop result
  logic pop_v_r, pop_v_nxt, pop_last_r, pop_last_nxt, acc_r, acc_nxt;

  // output register
  logic       ov_r;
  logic [7:0] ob_r;
  logic       obv_r, olast_r, oacc_r, oneed_r, oend_r;

  // code extraction
  logic [4:0]    shift;
  logic [23:0]   mask;
  logic [23:0]   shifted;
  logic [12:0]   code;
  logic          code_lt_nfc;
  logic [12:0]   nfc_inc;
  logic [12:0]   grow_at;
  logic          cur_literal;

  always_comb begin
    shift       = cnt_r - 5'(width_r);
    mask        = (24'd1 << width_r) - 24'd1;
    shifted     = buf_r >> shift;
    code        = 13'(shifted & mask);
    code_lt_nfc = (code < nfc_r);
    nfc_inc     = nfc_r + 13'd1;
    grow_at     = (13'd1 << width_r) - 13'd1;
    cur_literal = (13'(cur_r) < tld_pkg::FIRST_FREE);
  end

  assign sts.item_is_pull = (item_cmd_r == tld_pkg::CMD_PULL);
  assign sts.can_decode   = (level_r == 13'd0) && !fin_r && (cnt_r >= 5'(width_r));
  assign sts.start_unwind = (code != tld_pkg::END_CODE) && (code != tld_pkg::CODE_CLEAR)
                            && !fac_r;
  assign sts.unwind_done  = cur_literal;
  assign sts.out_free     = !ov_r || !out_stall;

  always_comb begin
    buf_nxt         = buf_r;
    cnt_nxt         = cnt_r;
    width_nxt       = width_r;
    nfc_nxt         = nfc_r;
    prev_nxt        = prev_r;
    prev_first_nxt  = prev_first_r;
    fac_nxt         = fac_r;
    fin_nxt         = fin_r;
    level_nxt       = level_r;
    cur_nxt         = cur_r;
    code_nxt        = code_r;
    kwk_nxt         = kwk_r;
    pop_v_nxt       = pop_v_r;
    pop_last_nxt    = pop_last_r;
    acc_nxt         = acc_r;
    stack_raddr_nxt = stack_raddr_r;
    stack_we        = 1'b0;
    stack_wdata     = 8'd0;
    entry_we        = 1'b0;
    entry_wdata     = '0;
    entry_raddr     = cur_r;

    if (ctl.do_push) begin
      pop_v_nxt    = 1'b0;
      pop_last_nxt = 1'b0;
      acc_nxt      = 1'b0;
      if (cnt_r <= tld_pkg::PUSH_ROOM) begin
        buf_nxt = {buf_r[15:0], item_byte_r};
        cnt_nxt = cnt_r + 5'd8;
        acc_nxt = 1'b1;
      end
    end

    if (ctl.latch_item) acc_nxt = 1'b0;

    if (ctl.do_decode) begin
      cnt_nxt = shift;
      buf_nxt = buf_r & ((24'd1 << shift) - 24'd1);
      if (code == tld_pkg::END_CODE) begin
        fin_nxt = 1'b1;
      end else if (code == tld_pkg::CODE_CLEAR) begin
        nfc_nxt   = tld_pkg::FIRST_FREE;
        width_nxt = tld_pkg::MIN_WIDTH;
        fac_nxt   = 1'b1;
      end else if (fac_r) begin
        if (code < 13'd256) begin
          stack_we       = 1'b1;
          stack_wdata    = code[7:0];
          level_nxt      = level_r + 13'd1;
          prev_nxt       = CW'(code);
          prev_first_nxt = code[7:0];
          fac_nxt        = 1'b0;
        end
      end else if (code_lt_nfc) begin
        cur_nxt  = CW'(code);
        code_nxt = CW'(code);
        kwk_nxt  = 1'b0;
      end else begin
        stack_we    = (level_r < tld_pkg::STACK_LIM);
        stack_wdata = prev_first_r;
        if (stack_we) level_nxt = level_r + 13'd1;
        cur_nxt  = prev_r;
        code_nxt = CW'(code);
        kwk_nxt  = 1'b1;
      end
      entry_raddr = cur_nxt;
    end

    if (ctl.unwind_step) begin
      stack_we    = (level_r < tld_pkg::STACK_LIM);
      if (stack_we) level_nxt = level_r + 13'd1;
      if (!cur_literal) begin
        stack_wdata = entry_q[7:0];
        cur_nxt     = entry_q[CW+7:8];
        entry_raddr = entry_q[CW+7:8];
      end else begin
        stack_wdata = cur_r[7:0];
        if (nfc_r < tld_pkg::TABLE_LIM) begin
          entry_we    = 1'b1;
          entry_wdata = {prev_r, (kwk_r ? prev_first_r : cur_r[7:0])};
          nfc_nxt     = nfc_inc;
          if ((width_r < tld_pkg::MAX_WIDTH) && (nfc_inc == grow_at))
            width_nxt = width_r + 4'd1;
        end
        prev_nxt       = kwk_r ? CW'(nfc_r) : code_r;
        prev_first_nxt = kwk_r ? prev_first_r : cur_r[7:0];
      end
    end

    if (ctl.do_pop) begin
      pop_v_nxt    = 1'b0;
      pop_last_nxt = 1'b0;
      if (level_r != 13'd0) begin
        level_nxt       = level_r - 13'd1;
        stack_raddr_nxt = SA'(level_nxt);
        pop_v_nxt       = 1'b1;
        pop_last_nxt    = (level_nxt == 13'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (entry_we) entry_mem[nfc_r[CW-1:0]] <= entry_wdata;
    entry_q <= entry_mem[entry_raddr];
    if (stack_we) stack_mem[level_r[SA-1:0]] <= stack_wdata;
    stack_q <= stack_mem[stack_raddr_nxt];
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_item) begin
      item_cmd_r  <= in_cmd;
      item_byte_r <= in_byte;
    end
    cur_r         <= cur_nxt;
    code_r        <= code_nxt;
    kwk_r         <= kwk_nxt;
    stack_raddr_r <= stack_raddr_nxt;
    pop_last_r    <= pop_last_nxt;
    acc_r         <= acc_nxt;
    if (ctl.load_out) begin
      ob_r    <= pop_v_r ? stack_q : 8'd0;
      obv_r   <= pop_v_r;
      olast_r <= pop_last_r;
      oacc_r  <= acc_r;
      oneed_r <= (level_r == 13'd0) && !fin_r && (cnt_r < 5'(width_r));
      oend_r  <= fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r          <= '0;
      cnt_r          <= '0;
      width_r        <= tld_pkg::MIN_WIDTH;
      nfc_r          <= tld_pkg::FIRST_FREE;
      prev_r         <= '0;
      prev_first_r   <= '0;
      fac_r          <= 1'b1;
      fin_r          <= 1'b0;
      level_r        <= '0;
      pop_v_r        <= 1'b0;
      ov_r           <= 1'b0;
    end else begin
      buf_r          <= buf_nxt;
      cnt_r          <= cnt_nxt;
      width_r        <= width_nxt;
      nfc_r          <= nfc_nxt;
      prev_r         <= prev_nxt;
      prev_first_r   <= prev_first_nxt;
      fac_r          <= fac_nxt;
      fin_r          <= fin_nxt;
      level_r        <= level_nxt;
      pop_v_r        <= pop_v_nxt;
      if (ctl.load_out)    ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  assign out_valid          = ov_r;
  assign out_byte           = ob_r;
  assign out_byte_valid     = obv_r;
  assign out_last_of_string = olast_r;
  assign out_push_accepted  = oacc_r;
  assign out_need_input     = oneed_r;
  assign out_end_of_data    = oend_r;

endmodule
`default_nettype wire

// ===== rtl/tiff_lzw_decoder.sv =====
// tiff_lzw_decoder: top level of the tiff lzw strip decoder
// depends on tld_pkg, tld_ctrl and tld_datapath
//
// usage: each input request carries in_cmd (push a compressed byte given on
// in_byte, or pull one decoded byte) and produces exactly one result request.
// both channels use valid/stall; a request moves when valid is high and
// stall is low. out_byte_valid marks a pull that delivered a byte,
// out_last_of_string the final byte of a code's string, out_push_accepted a
// stored push, out_need_input an empty stack with too few buffered bits.
// one request is handled at a time: a push passes the exec and resp states,
// a pull that only pops the stack exec, pop and resp; a decoding pull walks
// the prefix chain through the single-port string table in unwind steps
// between exec and pop: the string length for a code in the table, one less
// for one at or beyond the next free code, none for first, clear, end codes.
// the result sits in an output register; while the receiver stalls, the next
// request is still taken and worked on, and waits for the output register.
// reset (rst_n low, synchronous) empties the bit buffer and stack, sets
// 9-bit codes and an empty table; table and stack memories need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module tiff_lzw_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_cmd,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_last_of_string,
  output logic            out_push_accepted,
  output logic            out_need_input,
  output logic            out_end_of_data
);

  tld_pkg::ctl_t ctl;
  tld_pkg::sts_t sts;

  tld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  tld_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_cmd             (in_cmd),
    .in_byte            (in_byte),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_last_of_string (out_last_of_string),
    .out_push_accepted  (out_push_accepted),
    .out_need_input     (out_need_input),
    .out_end_of_data    (out_end_of_data),
    .ctl                (ctl),
    .sts                (sts)
  );

endmodule
`default_nettype wire

// ===== tb/lzw_checker.sv =====
// lzw_checker: watches the request and result channels of the lzw strip decoder,
// predicts every result from its own copy of the decoder state and compares
// depends on tld_pkg
`timescale 1ns / 1ps
module lzw_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic       in_cmd,
  input  wire logic [7:0] in_byte,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [7:0] out_byte,
  input  wire logic       out_byte_valid,
  input  wire logic       out_last_of_string,
  input  wire logic       out_push_accepted,
  input  wire logic       out_need_input,
  input  wire logic       out_end_of_data,
  output int              fail_count,
  output int              pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       byte_ok;
    logic       last;
    logic       accepted;
    logic       need;
    logic       eod;
  } lzw_result_t;

  lzw_result_t decoded_q[$];

  logic [23:0] bit_buf;
  logic [4:0]  bit_cnt;
  logic [3:0]  width;
  logic [12:0] next_code;
  logic [11:0] prev_code;
  logic        first_code;
  logic [12:0] stack_lvl;
  logic        done_flag;
  logic [11:0] prefix_mem [tld_pkg::TableSize];
  logic [7:0]  suffix_mem [tld_pkg::TableSize];
  logic [7:0]  head_mem   [tld_pkg::TableSize];
  logic [7:0]  string_mem [tld_pkg::StackDepth];

  function automatic logic [7:0] head_of(logic [12:0] c);
    if (c < 13'd256) return c[7:0];
    return head_mem[c[11:0]];
  endfunction

  task automatic stack_put(logic [7:0] b);
    if (stack_lvl < tld_pkg::STACK_LIM) begin
      string_mem[stack_lvl[11:0]] = b;
      stack_lvl++;
    end
  endtask

  task automatic unwind_chain(logic [12:0] c);
    int guard;
    guard = 0;
    while (c >= tld_pkg::FIRST_FREE && guard < 4096) begin
      stack_put(suffix_mem[c[11:0]]);
      c = {1'b0, prefix_mem[c[11:0]]};
      guard++;
    end
    stack_put(c[7:0]);
  endtask

  task automatic add_entry(logic [12:0] p, logic [7:0] s);
    logic [11:0] slot;
    if (next_code >= tld_pkg::TABLE_LIM) return;
    slot = next_code[11:0];
    prefix_mem[slot] = p[11:0];
    suffix_mem[slot] = s;
    head_mem[slot] = head_of(p);
    next_code++;
    if (width < tld_pkg::MAX_WIDTH && next_code == (13'd1 << width) - 13'd1) width++;
  endtask

  task automatic decode_code(logic [12:0] c);
    logic [12:0] made;
    logic [7:0]  f;
    if (c == tld_pkg::END_CODE) begin
      done_flag = 1'b1;
    end else if (c == tld_pkg::CODE_CLEAR) begin
      next_code = tld_pkg::FIRST_FREE;
      width = tld_pkg::MIN_WIDTH;
      first_code = 1'b1;
    end else if (first_code) begin
      if (c < 13'd256) begin
        stack_put(c[7:0]);
        prev_code = c[11:0];
        first_code = 1'b0;
      end
    end else if (c < next_code) begin
      unwind_chain(c);
      add_entry({1'b0, prev_code}, head_of(c));
      prev_code = c[11:0];
    end else begin
      made = next_code;
      f = head_of({1'b0, prev_code});
      stack_put(f);
      unwind_chain({1'b0, prev_code});
      add_entry({1'b0, prev_code}, f);
      prev_code = made[11:0];
    end
  endtask

  task automatic predict_request(logic cmd, logic [7:0] data, output lzw_result_t r);
    int shift;
    int code;
    r = '0;
    if (cmd == tld_pkg::CMD_PUSH) begin
      if (bit_cnt <= tld_pkg::PUSH_ROOM) begin
        bit_buf = {bit_buf[15:0], data};
        bit_cnt += 5'd8;
        r.accepted = 1'b1;
      end
    end else begin
      if (stack_lvl == 0 && !done_flag && bit_cnt >= width) begin
        shift = int'(bit_cnt) - int'(width);
        code = (int'(bit_buf) >> shift) & ((1 << width) - 1);
        bit_cnt = 5'(shift);
        bit_buf = 24'(int'(bit_buf) & ((1 << shift) - 1));
        decode_code(13'(code));
      end
      if (stack_lvl > 0) begin
        stack_lvl--;
        r.data = string_mem[stack_lvl[11:0]];
        r.byte_ok = 1'b1;
        r.last = (stack_lvl == 0);
      end
    end
    r.need = (stack_lvl == 0 && !done_flag && bit_cnt < width);
    r.eod = done_flag;
  endtask

  always @(posedge clk) begin
    lzw_result_t exp_r;
    lzw_result_t got_r;
    if (!rst_n) begin
      bit_buf <= '0;
      bit_cnt <= '0;
      width <= tld_pkg::MIN_WIDTH;
      next_code <= tld_pkg::FIRST_FREE;
      prev_code <= '0;
      first_code <= 1'b1;
      stack_lvl <= '0;
      done_flag <= 1'b0;
      fail_count <= 0;
      pending <= 0;
      decoded_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        predict_request(in_cmd, in_byte, exp_r);
        decoded_q.insert(decoded_q.size(), exp_r);
      end
      if (out_valid && !out_stall) begin
        got_r = {out_byte, out_byte_valid, out_last_of_string, out_push_accepted,
                 out_need_input, out_end_of_data};
        if (decoded_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result request at %0t", $realtime);
        end else begin
          exp_r = decoded_q.pop_front();
          if (got_r !== exp_r) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"mismatch at %0t: byte %h/%h valid %b/%b last %b/%b",
                        " acc %b/%b need %b/%b eod %b/%b"},
                       $realtime, exp_r.data, got_r.data, exp_r.byte_ok, got_r.byte_ok,
                       exp_r.last, got_r.last, exp_r.accepted, got_r.accepted,
                       exp_r.need, got_r.need, exp_r.eod, got_r.eod);
          end
        end
      end
      pending <= decoded_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// tb: stimulus and verdict for the lzw strip decoder; builds encoded strips
// with random content, drives requests and stalls, and reads lzw_checker
// depends on tld_pkg, tiff_lzw_decoder and lzw_checker
`timescale 1ns / 1ps
module tb;

  localparam int CycleLimit = 3000000;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } lzw_request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_cmd = tld_pkg::CMD_PUSH;
  logic [7:0] in_byte = '0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid, out_byte_valid, out_last_of_string;
  logic out_push_accepted, out_need_input, out_end_of_data;
  logic [7:0] out_byte;
  int fail_count, pending;

  lzw_request_t req_q[$];
  int bounds[6];
  int idx = 0;
  int cycles = 0;

  int enc_tab, enc_width, enc_prev;
  bit enc_first;
  int str_len[tld_pkg::TableSize];
  logic [31:0] acc;
  int acc_bits;
  int tail_cost;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tiff_lzw_decoder u_top (.*);

  lzw_checker u_checker (.*);

  task automatic add_push(logic [7:0] b);
    req_q.insert(req_q.size(), {tld_pkg::CMD_PUSH, b});
  endtask

  task automatic add_pulls(int n);
    repeat (n) req_q.insert(req_q.size(), {tld_pkg::CMD_PULL, 8'($urandom)});
  endtask

  task automatic emit_code(int c);
    int cost;
    int w;
    w = enc_width;
    cost = 1;
    if (c == int'(tld_pkg::CODE_CLEAR)) begin
      enc_tab = int'(tld_pkg::FIRST_FREE);
      enc_width = int'(tld_pkg::MIN_WIDTH);
      enc_first = 1'b1;
    end else if (c == int'(tld_pkg::END_CODE)) begin
      cost = 1;
    end else if (enc_first) begin
      if (c < 256) begin
        enc_prev = c;
        enc_first = 1'b0;
      end
    end else begin
      if (c < enc_tab) cost = str_len[c];
      else cost = str_len[enc_prev] + 1;
      if (enc_tab < int'(tld_pkg::TableSize)) begin
        str_len[enc_tab] = str_len[enc_prev] + 1;
        enc_prev = (c < enc_tab) ? c : enc_tab;
        enc_tab++;
        if (enc_width < int'(tld_pkg::MAX_WIDTH) && enc_tab == (1 << enc_width) - 1)
          enc_width++;
      end else begin
        enc_prev = c;
      end
    end
    acc = (acc << w) | 32'(c);
    acc_bits += w;
    while (acc_bits >= 8) begin
      add_push(8'(acc >> (acc_bits - 8)));
      acc_bits -= 8;
      add_pulls(tail_cost);
      tail_cost = 0;
    end
    acc &= (32'd1 << acc_bits) - 32'd1;
    if (acc_bits == 0) add_pulls(cost);
    else tail_cost = cost;
    if ($urandom_range(0, 9) == 0) add_pulls(1);
  endtask

  task automatic pad_flush();
    if (acc_bits > 0) begin
      add_push(8'(acc << (8 - acc_bits)));
      acc = '0;
      acc_bits = 0;
    end
    add_pulls(tail_cost + 1);
    tail_cost = 0;
  endtask

  function automatic int pick_code(bit literal_bias);
    int r;
    int c;
    r = $urandom_range(0, 99);
    if (enc_first) begin
      if (r < 5) return $urandom_range(258, 511);
      return $urandom_range(0, 255);
    end
    if (literal_bias && r < 90) return $urandom_range(0, 255);
    if (r < 2) return int'(tld_pkg::CODE_CLEAR);
    if (r < 12 && enc_tab < int'(tld_pkg::TableSize)) return enc_tab;
    if (r < 15 && enc_tab + 1 < (1 << enc_width))
      return enc_tab + 1 + $urandom_range(0, ((1 << enc_width) - enc_tab - 2) % 20);
    c = $urandom_range(0, enc_tab - 3);
    if (c >= 256) c += 2;
    return c;
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) str_len[i] = 1;
    enc_tab = int'(tld_pkg::FIRST_FREE);
    enc_width = int'(tld_pkg::MIN_WIDTH);
    enc_first = 1'b1;
    enc_prev = 0;
    acc = '0;
    acc_bits = 0;
    tail_cost = 0;

    // directed strip: empty pull, literal extremes, double clear, ignored codes,
    // a code equal to the next free code and one beyond it
    add_pulls(1);
    emit_code(0);
    emit_code(255);
    emit_code(int'(tld_pkg::CODE_CLEAR));
    emit_code(int'(tld_pkg::CODE_CLEAR));
    emit_code(300);
    emit_code(258);
    emit_code(65);
    emit_code(258);
    emit_code(270);
    emit_code(259);
    emit_code(66);

    while (req_q.size() < 500) emit_code(pick_code(1'b0));
    bounds[0] = req_q.size();
    while (req_q.size() < 900) emit_code(pick_code(1'b0));
    bounds[1] = req_q.size();
    while (req_q.size() < 1300) emit_code(pick_code(1'b0));
    bounds[2] = req_q.size();
    while (req_q.size() < 1900) emit_code(pick_code(1'b0));
    bounds[3] = req_q.size();
    bounds[4] = req_q.size();

    // end of data, then pushes past a full bit buffer and random pushes and pulls
    emit_code(int'(tld_pkg::END_CODE));
    pad_flush();
    repeat (5) add_push(8'($urandom));
    repeat (40) req_q.insert(req_q.size(), lzw_request_t'(9'($urandom)));
    bounds[5] = req_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int send_idle_pct(int i);
    if (i >= bounds[0] && i < bounds[1]) return 84;
    if (i >= bounds[2] && i < bounds[3]) return 24;
    if (i >= bounds[4]) return 24;
    return 0;
  endfunction

  function automatic int stall_pct(int i);
    if (i >= bounds[1] && i < bounds[2]) return 84;
    if (i >= bounds[2] && i < bounds[3]) return 24;
    if (i >= bounds[4]) return 24;
    return 0;
  endfunction

  always @(posedge clk) begin
    int nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      nxt = idx;
      if (in_valid && !in_stall) nxt = idx + 1;
      idx = nxt;
      if (!in_valid || !in_stall) begin
        if (nxt < req_q.size() && $urandom_range(0, 99) >= send_idle_pct(nxt)) begin
          in_valid <= 1'b1;
          in_cmd <= req_q[nxt].cmd;
          in_byte <= req_q[nxt].data;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct(nxt));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tiff_lzw_decoder test failed");
      $finish;
    end
  end

  initial begin
    wait (rst_n);
    while (idx < bounds[5]) @(posedge clk);
    while (pending > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tiff_lzw_decoder test passed");
    end else begin
      $display("tiff_lzw_decoder test failed");
    end
    $finish;
  end

endmodule
